// ===== hw/rtl/rds_group_text_decoder_macros.svh =====
// Assertion macros shared by the RDS group text decoder RTL.
// Each macro expects signals clk and rst_n in the including module.
`ifndef RDS_GROUP_TEXT_DECODER_MACROS_SVH
`define RDS_GROUP_TEXT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rdstxt_pkg.sv =====
// Types and constants for the RDS group text decoder.
// No dependencies; imported by rds_group_text_decoder.
`default_nettype none

package rdstxt_pkg;

    // Block numbers from status bits 7..5
    localparam logic [2:0] BLK_B = 3'd1;
    localparam logic [2:0] BLK_C = 3'd2;
    localparam logic [2:0] BLK_D = 3'd3;

    // Status bit set when a signal is present
    localparam int SIGNAL_BIT = 4;

    // Group codes (type and version)
    localparam logic [4:0] GRP_0A = 5'd0;
    localparam logic [4:0] GRP_2A = 5'd4;

    // Buffer selects
    localparam logic BUF_PS = 1'b0;
    localparam logic BUF_RT = 1'b1;

    // Final segment numbers
    localparam logic [1:0] PS_SEG_LAST = 2'd3;
    localparam logic [3:0] RT_SEG_LAST = 4'd15;

    // Character writes per block D
    localparam logic [2:0] PS_CHARS = 3'd2;
    localparam logic [2:0] RT_CHARS = 3'd4;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] data_high;
        logic [7:0] data_low;
    } item_t;

    typedef struct packed {
        logic       buffer_select;
        logic [5:0] char_index;
        logic [7:0] char_value;
        logic       message_complete;
        logic       last;
    } char_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rds_group_text_decoder.sv =====
// RDS group text decoder: readout register, block decode and character burst register.
// Depends on rdstxt_pkg and rds_group_text_decoder_macros.svh.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+--------------------------
//   item    | item_valid | item_stall | item   (item_t, in)
//   char    | char_valid | char_stall | char_wr (char_wr_t, out)
//
// A readout waits in the input register while a burst drains, then its decode loads
// the burst register, which issues its character writes one per cycle while
// char_stall is low, up to four writes per readout. Readouts that write nothing
// load an empty burst. A held readout is decoded at the edge where the last write
// of the previous burst is taken. Reset clears the latches and the valid flags.
`default_nettype none

`include "rds_group_text_decoder_macros.svh"

module rds_group_text_decoder
    import rdstxt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire item_t    item,
    output logic          char_valid,
    input  wire logic     char_stall,
    output char_wr_t      char_wr
);

    // Input register
    logic       in_full_reg, in_full_next;
    item_t      in_reg;

    // Decoder state
    logic [4:0] group_reg, group_next;
    logic [4:0] seg_reg, seg_next;
    logic [7:0] c_high_reg, c_high_next;
    logic [7:0] c_low_reg, c_low_next;
    logic [2:0] prev_blk_reg, prev_blk_next;
    logic       prev_valid_reg, prev_valid_next;

    // Burst register
    logic [7:0] val_reg [4];
    logic [7:0] val_next [4];
    logic [5:0] base_reg, base_next;
    logic       sel_reg, sel_next;
    logic       done_reg, done_next;
    logic [2:0] beats_reg, beats_next;
    logic [1:0] ptr_reg, ptr_next;

    logic       accept;
    logic       out_xfer;
    logic       advance;
    logic       consume;
    logic [2:0] blk;
    logic       take;

    // Decode results
    logic [2:0] ld_beats;
    logic [5:0] ld_base;
    logic       ld_sel;
    logic       ld_done;
    logic [7:0] ld_val [4];

    assign out_xfer   = char_valid && !char_stall;
    assign advance    = (beats_reg == 3'd0) || ((beats_reg == 3'd1) && !char_stall);
    assign consume    = in_full_reg && advance;
    assign item_stall = in_full_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign blk  = in_reg.status_byte[7:5];
    assign take = in_reg.status_byte[SIGNAL_BIT] && !(prev_valid_reg && (prev_blk_reg == blk));

    // Block decode and latch updates
    always_comb
    begin
        group_next      = group_reg;
        seg_next        = seg_reg;
        c_high_next     = c_high_reg;
        c_low_next      = c_low_reg;
        prev_blk_next   = prev_blk_reg;
        prev_valid_next = prev_valid_reg;
        ld_beats        = 3'd0;
        ld_base         = 6'd0;
        ld_sel          = BUF_PS;
        ld_done         = 1'b0;
        ld_val[0]       = in_reg.data_high;
        ld_val[1]       = in_reg.data_low;
        ld_val[2]       = in_reg.data_high;
        ld_val[3]       = in_reg.data_low;

        if (consume && take)
        begin
            prev_blk_next   = blk;
            prev_valid_next = 1'b1;
            case (blk)
                BLK_B:
                begin
                    group_next = in_reg.data_high[7:3];
                    seg_next   = in_reg.data_low[4:0];
                end
                BLK_C:
                begin
                    c_high_next = in_reg.data_high;
                    c_low_next  = in_reg.data_low;
                end
                BLK_D:
                begin
                    if (group_reg == GRP_0A)
                    begin
                        ld_beats = PS_CHARS;
                        ld_base  = {3'd0, seg_reg[1:0], 1'b0};
                        ld_sel   = BUF_PS;
                        ld_done  = (seg_reg[1:0] == PS_SEG_LAST);
                    end
                    else if (group_reg == GRP_2A)
                    begin
                        ld_beats  = RT_CHARS;
                        ld_base   = {seg_reg[3:0], 2'b00};
                        ld_sel    = BUF_RT;
                        ld_done   = (seg_reg[3:0] == RT_SEG_LAST);
                        // radiotext leads with the two bytes held from block C
                        ld_val[0] = c_high_reg;
                        ld_val[1] = c_low_reg;
                    end
                end
                default:
                begin
                    // block A and codes 4..7: number only
                end
            endcase
        end
    end

    // Burst register next values
    always_comb
    begin
        base_next  = base_reg;
        sel_next   = sel_reg;
        done_next  = done_reg;
        beats_next = beats_reg;
        ptr_next   = ptr_reg;
        for (int i = 0; i < 4; i++)
        begin
            val_next[i] = val_reg[i];
        end

        if (consume)
        begin
            base_next  = ld_base;
            sel_next   = ld_sel;
            done_next  = ld_done;
            beats_next = ld_beats;
            ptr_next   = 2'd0;
            for (int i = 0; i < 4; i++)
            begin
                val_next[i] = ld_val[i];
            end
        end
        else if (out_xfer)
        begin
            // advance to the next character
            beats_next = beats_reg - 3'd1;
            ptr_next   = ptr_reg + 2'd1;
            for (int i = 0; i < 3; i++)
            begin
                val_next[i] = val_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            group_reg      <= 5'd0;
            seg_reg        <= 5'd0;
            c_high_reg     <= 8'd0;
            c_low_reg      <= 8'd0;
            prev_blk_reg   <= 3'd0;
            prev_valid_reg <= 1'b0;
            beats_reg      <= 3'd0;
            ptr_reg        <= 2'd0;
        end
        else
        begin
            in_full_reg    <= in_full_next;
            group_reg      <= group_next;
            seg_reg        <= seg_next;
            c_high_reg     <= c_high_next;
            c_low_reg      <= c_low_next;
            prev_blk_reg   <= prev_blk_next;
            prev_valid_reg <= prev_valid_next;
            beats_reg      <= beats_next;
            ptr_reg        <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        base_reg <= base_next;
        sel_reg  <= sel_next;
        done_reg <= done_next;
        for (int i = 0; i < 4; i++)
        begin
            val_reg[i] <= val_next[i];
        end
    end

    assign char_valid               = (beats_reg != 3'd0);
    assign char_wr.buffer_select    = sel_reg;
    assign char_wr.char_index       = base_reg | {4'd0, ptr_reg};
    assign char_wr.char_value       = val_reg[0];
    assign char_wr.message_complete = done_reg;
    assign char_wr.last             = (beats_reg == 3'd1);

    `RDS_ASSERT_NOW(a_beats_range, 1'b1, beats_reg <= RT_CHARS, "burst count out of range")
    `RDS_ASSERT_NOW(a_ps_index, char_valid && (char_wr.buffer_select == BUF_PS),
        char_wr.char_index[5:3] == 3'd0, "name write beyond eight characters")
    `RDS_ASSERT_NEXT(a_burst_holds, out_xfer && !char_wr.last, char_valid,
        "burst ended before its last write")
    `RDS_ASSERT_NOW(a_stall_full, item_stall, in_full_reg && (beats_reg != 3'd0),
        "readout stalled with nothing held")

endmodule

`default_nettype wire

// ===== test/rds_group_text_decoder_test.sv =====
// Self-checking bench for rds_group_text_decoder: readout transfers from a queue,
// character writes checked against a behavioural decode held in this file.
// Depends on rdstxt_pkg and the decoder RTL.
module rds_group_text_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdstxt_pkg::*;

    localparam logic [2:0] BLK_A        = 3'd0;
    localparam logic [2:0] BLK_SPARE    = 3'd4;   // first of the unused numbers 4..7
    localparam int IDLE_PCT             = 26;
    localparam int HOLD_CYCLES          = 90;
    localparam int HOLD_AFTER_WRITES    = 60;
    localparam int WATCHDOG_LIMIT       = 4000;
    localparam int DRAIN_CYCLES         = 16;
    localparam int TOTAL_READOUTS       = 410;
    localparam int PAUSE_AT_READOUT     = 230;

    typedef struct {
        bit    pause;
        item_t data;
    } pending_t;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     item_valid = 1'b0;
    item_t    item       = '0;
    logic     char_stall = 1'b0;
    logic     item_stall;
    logic     char_valid;
    char_wr_t char_wr;

    pending_t pending_readouts[$];
    char_wr_t due_writes[$];

    // Decoder state as seen by the bench
    logic [4:0] latched_group   = '0;
    logic [4:0] latched_segment = '0;
    logic [7:0] latched_c_high  = '0;
    logic [7:0] latched_c_low   = '0;
    logic [2:0] last_blk        = '0;
    logic       blk_seen        = 1'b0;

    // Stimulus bookkeeping: readouts queued so far and the latest one
    item_t      gen_last_item = '0;
    int         queued_readouts = 0;

    int readouts_taken = 0;
    int writes_seen    = 0;
    int failures       = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int stuck_cycles   = 0;

    rds_group_text_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_wr    (char_wr)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void decode_readout(item_t rd);
        logic [2:0] blk;
        logic [7:0] chars [4];
        logic       sel;
        logic       done;
        logic [5:0] base;
        int         count;
        char_wr_t   wr;
        count = 0;
        sel   = BUF_PS;
        done  = 1'b0;
        base  = '0;
        if (!rd.status_byte[SIGNAL_BIT])
            return;
        blk = rd.status_byte[7:5];
        if (blk_seen && blk == last_blk)
            return;
        last_blk = blk;
        blk_seen = 1'b1;
        case (blk)
            BLK_B:
            begin
                latched_group   = rd.data_high[7:3];
                latched_segment = rd.data_low[4:0];
            end
            BLK_C:
            begin
                latched_c_high = rd.data_high;
                latched_c_low  = rd.data_low;
            end
            BLK_D:
            begin
                if (latched_group == GRP_0A)
                begin
                    count    = PS_CHARS;
                    sel      = BUF_PS;
                    base     = {3'b000, latched_segment[1:0], 1'b0};
                    done     = (latched_segment[1:0] == PS_SEG_LAST);
                    chars[0] = rd.data_high;
                    chars[1] = rd.data_low;
                end
                else if (latched_group == GRP_2A)
                begin
                    count    = RT_CHARS;
                    sel      = BUF_RT;
                    base     = {latched_segment[3:0], 2'b00};
                    done     = (latched_segment[3:0] == RT_SEG_LAST);
                    chars[0] = latched_c_high;
                    chars[1] = latched_c_low;
                    chars[2] = rd.data_high;
                    chars[3] = rd.data_low;
                end
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < count; k++)
        begin
            wr.buffer_select    = sel;
            wr.char_index       = base + 6'(k);
            wr.char_value       = chars[k];
            wr.message_complete = done;
            wr.last             = (k == count - 1);
            due_writes.push_back(wr);
        end
    endfunction

    function automatic void queue_raw(item_t rd);
        pending_t p;
        p.pause = 1'b0;
        p.data  = rd;
        pending_readouts.push_back(p);
        gen_last_item = rd;
        queued_readouts++;
    endfunction

    function automatic void queue_readout(logic [2:0] blk, logic sig,
                                          logic [7:0] hi, logic [7:0] lo);
        item_t rd;
        rd.status_byte = {blk, sig, 4'($urandom)};
        rd.data_high   = hi;
        rd.data_low    = lo;
        queue_raw(rd);
    endfunction

    function automatic void queue_pause();
        pending_t p;
        p.pause = 1'b1;
        p.data  = '0;
        pending_readouts.push_back(p);
    endfunction

    function automatic void build_directed();
        queue_readout(BLK_D, 1'b0, 8'hff, 8'hff);              // no signal
        queue_readout(BLK_D, 1'b1, 8'hff, 8'h00);              // D on reset latches
        queue_readout(BLK_D, 1'b1, 8'h12, 8'h34);              // repeated number
        queue_readout(BLK_A, 1'b1, 8'hff, 8'hff);
        queue_readout(BLK_B, 1'b1, {GRP_2A, 3'b111}, 8'hff);   // final radiotext segment
        queue_readout(BLK_C, 1'b1, 8'hff, 8'h00);
        queue_readout(BLK_D, 1'b1, 8'h00, 8'hff);
        for (int k = 0; k < 4; k++)
            queue_readout(BLK_SPARE + 3'(k), 1'b1, 8'($urandom), 8'($urandom));
        queue_readout(BLK_B, 1'b1, {GRP_0A, 3'b000}, 8'he3);   // final name segment
        queue_readout(BLK_B, 1'b1, 8'hff, 8'hff);              // repeated B, ignored
        queue_readout(BLK_D, 1'b1, 8'h41, 8'h42);
        queue_readout(BLK_B, 1'b1, 8'hf8, 8'h00);              // unsupported group
        queue_readout(BLK_D, 1'b1, 8'hff, 8'hff);
        queue_readout(BLK_B, 1'b1, {GRP_2A, 3'b000}, 8'h00);
        queue_readout(BLK_C, 1'b1, 8'h00, 8'hff);
        queue_readout(BLK_D, 1'b1, 8'haa, 8'h55);
        queue_readout(BLK_C, 1'b1, 8'h5a, 8'ha5);              // C then D without a new B
        queue_readout(BLK_D, 1'b1, 8'h00, 8'h00);
        queue_pause();
    endfunction

    function automatic void build_random();
        int         pick;
        int         grp_pick;
        logic [4:0] code;
        item_t      rd;
        bit         paused;
        paused = 1'b0;
        while (queued_readouts < TOTAL_READOUTS)
        begin
            if (!paused && queued_readouts >= PAUSE_AT_READOUT)
            begin
                queue_pause();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                grp_pick = $urandom_range(0, 99);
                if (grp_pick < 40)
                    code = GRP_0A;
                else if (grp_pick < 80)
                    code = GRP_2A;
                else
                    code = 5'($urandom);
                if ($urandom_range(0, 1))
                    queue_readout(BLK_A, 1'b1, 8'($urandom), 8'($urandom));
                queue_readout(BLK_B, 1'b1, {code, 3'($urandom)}, 8'($urandom));
                queue_readout(BLK_C, 1'b1, 8'($urandom), 8'($urandom));
                queue_readout(BLK_D, 1'b1, 8'($urandom), 8'($urandom));
            end
            else if (pick < 80)
            begin
                rd = item_t'(24'($urandom));
                queue_raw(rd);
            end
            else if (pick < 88)
                queue_readout(3'($urandom), 1'b0, 8'($urandom), 8'($urandom));
            else if (pick < 94)
                queue_raw(gen_last_item);
            else
            begin
                // broken group: B and D with the old C latch
                queue_readout(BLK_B, 1'b1, {GRP_2A, 3'($urandom)}, 8'($urandom));
                queue_readout(BLK_D, 1'b1, 8'($urandom), 8'($urandom));
            end
        end
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    // Driver: offer queued readouts, idle at random outside a quiet window, hold at a pause marker until drained
    always @(posedge clk or negedge rst_n)
    begin
        pending_t head;
        bit       quiet;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                decode_readout(item);
                readouts_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                quiet = (readouts_taken >= 150 && readouts_taken < 260);
                if (pending_readouts.size() > 0 && pending_readouts[0].pause
                    && due_writes.size() == 0)
                    void'(pending_readouts.pop_front());
                if (pending_readouts.size() > 0 && !pending_readouts[0].pause
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    head = pending_readouts.pop_front();
                    item       <= head.data;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each character write transfer, drive the stall
    always @(posedge clk or negedge rst_n)
    begin
        char_wr_t want;
        if (!rst_n)
            char_stall <= 1'b0;
        else
        begin
            if (char_valid && !char_stall)
            begin
                writes_seen++;
                if (due_writes.size() == 0)
                begin
                    $error("character write with none due: %p", char_wr);
                    failures++;
                end
                else
                begin
                    want = due_writes.pop_front();
                    check_field("buffer_select", want.buffer_select, char_wr.buffer_select);
                    check_field("char_index", want.char_index, char_wr.char_index);
                    check_field("char_value", want.char_value, char_wr.char_value);
                    check_field("message_complete", want.message_complete,
                                char_wr.message_complete);
                    check_field("last", want.last, char_wr.last);
                end
            end
            // hold off once for a long stretch so the decoder backs up into its input
            if (!hold_done && writes_seen >= HOLD_AFTER_WRITES)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_stall <= 1'b1;
            end
            else if (writes_seen >= 250 && writes_seen < 400)
                char_stall <= 1'b0;
            else
                char_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (char_valid && !char_stall))
            stuck_cycles = 0;
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[rds_group_text_decoder] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        build_directed();
        build_random();
        wait (rst_n);
        // sample between edges so the driver's updates have settled
        while (pending_readouts.size() > 0 || item_valid || due_writes.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_writes.size() != 0)
        begin
            $error("character writes still due at end: %0d", due_writes.size());
            failures++;
        end
        if (failures == 0)
            $display("[rds_group_text_decoder] OK");
        else
            $display("[rds_group_text_decoder] ERROR");
        $finish;
    end

endmodule

// ===== rds_group_text_decoder.f =====
+incdir+hw/rtl
hw/rtl/rdstxt_pkg.sv
hw/rtl/rds_group_text_decoder.sv
test/rds_group_text_decoder_test.sv
